/* rtl/core/setq_pkg.sv */
// shared types and codes of the sorted expiry timer queue
package setq_pkg;

    localparam int ID_BITS   = 5;
    localparam int NUM_IDS   = 32;
    localparam int OP_BITS   = 2;
    localparam int STAT_BITS = 3;

    localparam logic [OP_BITS-1:0] OP_ADD    = 2'd0;
    localparam logic [OP_BITS-1:0] OP_ADJUST = 2'd1;
    localparam logic [OP_BITS-1:0] OP_DELETE = 2'd2;
    localparam logic [OP_BITS-1:0] OP_TICK   = 2'd3;

    localparam logic [STAT_BITS-1:0] STAT_DONE    = 3'd0;
    localparam logic [STAT_BITS-1:0] STAT_EXPIRED = 3'd1;
    localparam logic [STAT_BITS-1:0] STAT_NONE    = 3'd2;
    localparam logic [STAT_BITS-1:0] STAT_FULL    = 3'd3;
    localparam logic [STAT_BITS-1:0] STAT_UNKNOWN = 3'd4;
    localparam logic [STAT_BITS-1:0] STAT_IN_USE  = 3'd5;

    typedef struct packed {
        logic insert;
        logic remove;
    } setq_cmd_t;

endpackage

/* rtl/core/sorted_expiry_timer_queue.sv */
// top level of the sorted expiry timer queue
//
// Input channel s_*: one item per operation (add, adjust, delete, tick).
// Result channel m_*: add, adjust and delete give one item with tlast set;
// a tick gives one expired item per removed timer, tlast on the final one,
// or a single none-expired item when nothing is due.
// Timers sit in a chain of CAPACITY cells sorted by expiry; an insert or a
// removal shifts every cell past its point by one cell, all together.
// Add and delete write their result register directly; adjust removes the
// timer, then reinserts it in the ADJ state; a tick is accepted, then the
// TICK state compares the head and gives one item per expired timer.
// Throughput: one add or delete per cycle while the receiver takes each
// result; an adjust or a tick holds off new input items until it is done.
// Reset empties the chain and the id table at once; no sweep is needed.
// While the receiver stalls the result register holds its item, a tick pauses
// between expired items and no new input item is taken.
module sorted_expiry_timer_queue #(
    parameter int CAPACITY  = 32,
    parameter int TIME_BITS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // operation, timer_id, expire_time, now
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // status, expired_id
    output logic        m_tlast
);
    import setq_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_ADJ  = 2'd1;
    localparam logic [1:0] ST_TICK = 2'd2;

    logic [1:0]           state_reg;
    logic [1:0]           state_next;
    logic [NUM_IDS-1:0]   in_use_reg;
    logic [NUM_IDS-1:0]   in_use_next;
    logic                 m_valid_reg;
    logic                 m_valid_next;
    logic [STAT_BITS-1:0] m_status_reg;
    logic [STAT_BITS-1:0] m_status_next;
    logic [ID_BITS-1:0]   m_id_reg;
    logic [ID_BITS-1:0]   m_id_next;
    logic                 m_last_reg;
    logic                 m_last_next;
    logic [TIME_BITS-1:0] time_reg;
    logic [ID_BITS-1:0]   hold_id_reg;

    logic [OP_BITS-1:0]   op_in;
    logic [ID_BITS-1:0]   id_in;
    logic [TIME_BITS-1:0] exp_in;
    logic [TIME_BITS-1:0] now_in;

    setq_cmd_t            cmd;
    logic                 pop;
    logic [TIME_BITS-1:0] new_exp;
    logic [ID_BITS-1:0]   new_id;
    logic                 accept;
    logic                 out_free;
    logic                 head_due;
    logic                 next_due;

    logic [CAPACITY-1:0]  cell_valid;
    logic [TIME_BITS-1:0] cell_exp [CAPACITY];
    logic [ID_BITS-1:0]   cell_id  [CAPACITY];
    logic [CAPACITY:0]    gt_chain;
    logic [CAPACITY:0]    hit_chain;

    assign op_in  = s_tdata[1:0];
    assign id_in  = s_tdata[6:2];
    assign exp_in = TIME_BITS'(s_tdata[38:7]);
    assign now_in = TIME_BITS'(s_tdata[70:39]);

    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && out_free;
    assign accept   = s_tvalid && s_tready;

    assign new_exp = (state_reg == ST_IDLE) ? exp_in : time_reg;
    assign new_id  = (state_reg == ST_IDLE) ? id_in : hold_id_reg;

    assign head_due = cell_valid[0] && (cell_exp[0] <= time_reg);
    assign next_due = cell_valid[1] && (cell_exp[1] <= time_reg);

    assign gt_chain[0]  = 1'b0;
    assign hit_chain[0] = pop;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            logic                 lv;
            logic [TIME_BITS-1:0] le;
            logic [ID_BITS-1:0]   li;
            logic                 rv;
            logic [TIME_BITS-1:0] re;
            logic [ID_BITS-1:0]   ri;

            if (gi == 0) begin : g_first
                assign lv = 1'b0;
                assign le = '0;
                assign li = '0;
            end else begin : g_mid
                assign lv = cell_valid[gi-1];
                assign le = cell_exp[gi-1];
                assign li = cell_id[gi-1];
            end

            if (gi == CAPACITY - 1) begin : g_end
                assign rv = 1'b0;
                assign re = '0;
                assign ri = '0;
            end else begin : g_inner
                assign rv = cell_valid[gi+1];
                assign re = cell_exp[gi+1];
                assign ri = cell_id[gi+1];
            end

            setq_cell #(
                .TIME_BITS(TIME_BITS)
            ) u_cell (
                .aclk        (aclk),
                .aresetn     (aresetn),
                .cmd         (cmd),
                .new_exp     (new_exp),
                .new_id      (new_id),
                .left_valid  (lv),
                .left_exp    (le),
                .left_id     (li),
                .left_gt     (gt_chain[gi]),
                .right_valid (rv),
                .right_exp   (re),
                .right_id    (ri),
                .hit_in      (hit_chain[gi]),
                .valid       (cell_valid[gi]),
                .exp_out     (cell_exp[gi]),
                .id_out      (cell_id[gi]),
                .gt          (gt_chain[gi+1]),
                .hit_out     (hit_chain[gi+1])
            );
        end
    endgenerate

    always_comb begin
        state_next    = state_reg;
        in_use_next   = in_use_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_status_next = m_status_reg;
        m_id_next     = m_id_reg;
        m_last_next   = m_last_reg;
        cmd           = '0;
        pop           = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (op_in)
                        OP_ADD: begin
                            m_valid_next = 1'b1;
                            m_id_next    = id_in;
                            m_last_next  = 1'b1;
                            if (in_use_reg[id_in]) begin
                                m_status_next = STAT_IN_USE;
                            end else if (cell_valid[CAPACITY-1]) begin
                                m_status_next = STAT_FULL;
                            end else begin
                                cmd.insert         = 1'b1;
                                in_use_next[id_in] = 1'b1;
                                m_status_next      = STAT_DONE;
                            end
                        end
                        OP_ADJUST: begin
                            if (!in_use_reg[id_in]) begin
                                m_valid_next  = 1'b1;
                                m_id_next     = id_in;
                                m_last_next   = 1'b1;
                                m_status_next = STAT_UNKNOWN;
                            end else begin
                                cmd.remove = 1'b1;
                                state_next = ST_ADJ;
                            end
                        end
                        OP_DELETE: begin
                            m_valid_next = 1'b1;
                            m_id_next    = id_in;
                            m_last_next  = 1'b1;
                            if (!in_use_reg[id_in]) begin
                                m_status_next = STAT_UNKNOWN;
                            end else begin
                                cmd.remove         = 1'b1;
                                in_use_next[id_in] = 1'b0;
                                m_status_next      = STAT_DONE;
                            end
                        end
                        OP_TICK: begin
                            state_next = ST_TICK;
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_ADJ: begin
                cmd.insert    = 1'b1;
                m_valid_next  = 1'b1;
                m_id_next     = hold_id_reg;
                m_last_next   = 1'b1;
                m_status_next = STAT_DONE;
                state_next    = ST_IDLE;
            end
            ST_TICK: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    if (head_due) begin
                        cmd.remove              = 1'b1;
                        pop                     = 1'b1;
                        in_use_next[cell_id[0]] = 1'b0;
                        m_status_next           = STAT_EXPIRED;
                        m_id_next               = cell_id[0];
                        m_last_next             = !next_due;
                        if (!next_due) begin
                            state_next = ST_IDLE;
                        end
                    end else begin
                        m_status_next = STAT_NONE;
                        m_id_next     = '0;
                        m_last_next   = 1'b1;
                        state_next    = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            in_use_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            in_use_reg  <= in_use_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_status_reg <= m_status_next;
        m_id_reg     <= m_id_next;
        m_last_reg   <= m_last_next;
        if (accept) begin
            time_reg    <= (op_in == OP_TICK) ? now_in : exp_in;
            hold_id_reg <= id_in;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_id_reg, m_status_reg};
    assign m_tlast  = m_last_reg;

    // id table and chain agree except mid-adjust
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_ADJ) |-> ($countones(in_use_reg) == $countones(cell_valid)))
        else $error("id table out of step with timer chain");

    // occupied cells form one block from the head
    assert property (@(posedge aclk) disable iff (!aresetn)
        ((cell_valid >> 1) & ~cell_valid) == '0)
        else $error("gap in timer chain");

    // a removal always finds its timer
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.remove |-> hit_chain[CAPACITY])
        else $error("removal found no timer");

    // an insert always finds the tail cell empty or later than the new timer
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.insert |-> gt_chain[CAPACITY])
        else $error("insert into full chain");

endmodule

/* rtl/core/setq_cell.sv */
// one slot of the sorted timer chain: holds a timer, shifts right on insert, left on remove
module setq_cell #(
    parameter int TIME_BITS = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  setq_pkg::setq_cmd_t           cmd,
    input  logic [TIME_BITS-1:0]          new_exp,
    input  logic [setq_pkg::ID_BITS-1:0]  new_id,
    input  logic                          left_valid,
    input  logic [TIME_BITS-1:0]          left_exp,
    input  logic [setq_pkg::ID_BITS-1:0]  left_id,
    input  logic                          left_gt,
    input  logic                          right_valid,
    input  logic [TIME_BITS-1:0]          right_exp,
    input  logic [setq_pkg::ID_BITS-1:0]  right_id,
    input  logic                          hit_in,
    output logic                          valid,
    output logic [TIME_BITS-1:0]          exp_out,
    output logic [setq_pkg::ID_BITS-1:0]  id_out,
    output logic                          gt,
    output logic                          hit_out
);
    import setq_pkg::*;

    logic                 valid_reg;
    logic                 valid_next;
    logic [TIME_BITS-1:0] exp_reg;
    logic [TIME_BITS-1:0] exp_next;
    logic [ID_BITS-1:0]   id_reg;
    logic [ID_BITS-1:0]   id_next;

    // slot is past the insert point when empty or strictly later
    assign gt      = !valid_reg || (exp_reg > new_exp);
    assign hit_out = hit_in || (valid_reg && (id_reg == new_id));

    always_comb begin
        valid_next = valid_reg;
        exp_next   = exp_reg;
        id_next    = id_reg;
        if (cmd.insert && gt) begin
            if (left_gt) begin
                valid_next = left_valid;
                exp_next   = left_exp;
                id_next    = left_id;
            end else begin
                valid_next = 1'b1;
                exp_next   = new_exp;
                id_next    = new_id;
            end
        end else if (cmd.remove && hit_out) begin
            valid_next = right_valid;
            exp_next   = right_exp;
            id_next    = right_id;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        exp_reg <= exp_next;
        id_reg  <= id_next;
    end

    assign valid   = valid_reg;
    assign exp_out = exp_reg;
    assign id_out  = id_reg;

endmodule
